// ===== rtl/core/madt_pkg.sv =====
// Package with shared constants and types for the mesh attached device table.
`default_nettype none
package madt_pkg;
  localparam int unsigned LocalSlots = 16;
  localparam int unsigned ChildSlots = 8;
  localparam logic [31:0] NoneId = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    StPlaced   = 2'd0,
    StNoParent = 2'd1,
    StFull     = 2'd2
  } status_e;

  typedef enum logic {
    CmdLocal = 1'b0,
    CmdDown  = 1'b1
  } command_e;

  typedef enum logic [2:0] {
    FsmIdle,
    FsmLocScan,
    FsmChildScan,
    FsmLocPlace,
    FsmParScan,
    FsmChildPlace,
    FsmDone
  } fsm_e;
endpackage
`default_nettype wire

// ===== rtl/core/mesh_attached_device_table_unit.sv =====
// Top level of the mesh attached device table: sequencer over two slot memories.
//
// Usage: one input channel (valid_i / stall_o) carries an item with command_i,
// device_id_i and parent_id_i. One output channel (valid_o / stall_i) carries
// exactly one result item per input item: status_o, remove_needed_o,
// remove_dest_o and remove_device_o. A separate config channel
// (cfg_valid_i / cfg_ready_o) writes the one-bit gateway mode register; it is
// always ready and must only be written while the block is idle.
//
// The local and child slot ids live in synchronous memories with registered
// reads; vacant bits live in flip-flops set to vacant by reset, so no
// clearing pass is needed. An item is handled one at a time by a sequencer
// that reads one entry at a time (address, then data). Command 1 checks each
// local slot and then its children, searches the local slots for the parent,
// places into a vacant child slot of that parent if found, and then ends in
// the final state. Command 0 scans every child slot and then places into the
// local slots. A new item is taken only once the sequencer is back in idle
// after the result register loads, so the block never takes a new item before
// it is through with the last. While the receiver stalls the result holds in
// the output register; the next item is still processed, and its result waits
// in the final state until the register frees. Reset empties both tables and
// clears gateway mode.
`default_nettype none
module mesh_attached_device_table_unit
  import madt_pkg::*;
#(
  parameter int unsigned LOCAL_SLOTS = LocalSlots,
  parameter int unsigned CHILD_SLOTS = ChildSlots
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic        command_i,
  input  wire logic [31:0] device_id_i,
  input  wire logic [31:0] parent_id_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [1:0]       status_o,
  output logic             remove_needed_o,
  output logic [31:0]      remove_dest_o,
  output logic [31:0]      remove_device_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i
);
  localparam int unsigned LW = (LOCAL_SLOTS > 1) ? $clog2(LOCAL_SLOTS) : 1;
  localparam int unsigned CW = (CHILD_SLOTS > 1) ? $clog2(CHILD_SLOTS) : 1;
  localparam int unsigned KN = LOCAL_SLOTS * CHILD_SLOTS;
  localparam int unsigned KW = (KN > 1) ? $clog2(KN) : 1;
  localparam logic [LW-1:0] LLast = LW'(LOCAL_SLOTS - 1);
  localparam logic [CW-1:0] CLast = CW'(CHILD_SLOTS - 1);

  // Memories for ids; vacant bits in flip-flops.
  logic [31:0] loc_mem [LOCAL_SLOTS];
  logic [31:0] chd_mem [KN];
  logic [LOCAL_SLOTS-1:0] loc_vac_q;
  logic [KN-1:0] chd_vac_q;

  fsm_e state_q, state_d;
  logic [LW-1:0] p_q, p_d;
  logic [CW-1:0] c_q, c_d;
  logic          cmd_q;
  logic [31:0]   dev_q, par_q;
  logic          gw_q;
  logic          need_q, need_d;
  logic [31:0]   dest_q, dest_d;
  logic          found_q, found_d;   // parent slot found in parent scan
  logic [LW-1:0] fp_q, fp_d;         // found parent slot
  logic [1:0]    stat_q, stat_d;
  logic          outv_q;
  logic          rd_vld_q;           // read data matches the current index

  logic [31:0] loc_rd_q, chd_rd_q;
  logic [LW-1:0] loc_ra;
  logic [KW-1:0] chd_ra;
  logic        loc_we, chd_we;
  logic [LW-1:0] loc_wa;
  logic [KW-1:0] chd_wa;
  logic [31:0] loc_wd;

  logic accept;
  assign accept = valid_i && !stall_o;
  assign stall_o = (state_q != FsmIdle);
  assign cfg_ready_o = 1'b1;

  // Child index p*CHILD_SLOTS + c, computed without a generic multiplier.
  logic [KW-1:0] k_scan, k_place;
  assign k_scan  = KW'(p_q * CHILD_SLOTS) + KW'(c_q);
  assign k_place = KW'(fp_q * CHILD_SLOTS) + KW'(c_q);

  // Read addresses follow the current scan position.
  always_comb begin
    loc_ra = p_q;
    chd_ra = (state_q == FsmChildPlace) ? k_place : k_scan;
  end

  always_ff @(posedge clk_i) begin
    loc_rd_q <= loc_mem[loc_ra];
    chd_rd_q <= chd_mem[chd_ra];
    if (loc_we) loc_mem[loc_wa] <= loc_wd;
    if (chd_we) chd_mem[chd_wa] <= dev_q;
  end

  logic loc_hit, chd_hit;
  assign loc_hit = !loc_vac_q[p_q] && (loc_rd_q == dev_q);
  assign chd_hit = !chd_vac_q[k_scan] && (chd_rd_q == dev_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      FsmIdle: begin
        // Command 1 checks the first local slot before its children.
        if (accept) state_d = (command_i == CmdDown) ? FsmLocScan : FsmChildScan;
      end
      FsmChildScan: begin
        if (rd_vld_q && (c_q == CLast)) begin
          if (cmd_q == CmdDown) begin
            if (p_q == LLast) state_d = FsmParScan;
            else state_d = FsmLocScan;
          end else if (p_q == LLast) begin
            state_d = FsmLocPlace;
          end
        end
      end
      FsmLocScan: if (rd_vld_q) state_d = FsmChildScan;
      FsmLocPlace: begin
        if (rd_vld_q && (loc_vac_q[p_q] || loc_rd_q == dev_q || p_q == LLast)) begin
          state_d = FsmDone;
        end
      end
      FsmParScan: begin
        if (rd_vld_q) begin
          if (!loc_vac_q[p_q] && loc_rd_q == par_q) state_d = FsmChildPlace;
          else if (p_q == LLast) state_d = FsmDone;
        end
      end
      FsmChildPlace: begin
        if (chd_vac_q[k_place] || c_q == CLast) state_d = FsmDone;
      end
      FsmDone: if (!outv_q || !stall_i) state_d = FsmIdle;
      default: state_d = FsmIdle;
    endcase
  end

  // Datapath and memory writes.
  always_comb begin
    p_d = p_q;
    c_d = c_q;
    need_d = need_q;
    dest_d = dest_q;
    found_d = found_q;
    fp_d = fp_q;
    stat_d = stat_q;
    loc_we = 1'b0;
    loc_wa = p_q;
    loc_wd = dev_q;
    chd_we = 1'b0;
    chd_wa = k_place;
    case (state_q)
      FsmIdle: begin
        p_d = '0;
        c_d = '0;
        need_d = 1'b0;
        dest_d = '0;
        found_d = 1'b0;
        fp_d = '0;
        stat_d = StNoParent;
      end
      FsmChildScan: begin
        if (rd_vld_q) begin
          if (chd_hit && (cmd_q == CmdDown) && gw_q) begin
            // Local slot state already reflects this request's vacating.
            if (loc_vac_q[p_q]) begin
              need_d = 1'b1;
              dest_d = NoneId;
            end else if (loc_rd_q != par_q) begin
              need_d = 1'b1;
              dest_d = loc_rd_q;
            end
          end
          if (c_q == CLast) begin
            c_d = '0;
            if (p_q == LLast) p_d = '0;
            else p_d = p_q + 1'b1;
          end else begin
            c_d = c_q + 1'b1;
          end
        end
      end
      FsmLocPlace: begin
        if (rd_vld_q) begin
          if (loc_vac_q[p_q] || loc_rd_q == dev_q) begin
            loc_we = 1'b1;
            stat_d = StPlaced;
          end else if (p_q == LLast) begin
            stat_d = StFull;
          end else begin
            p_d = p_q + 1'b1;
          end
        end
      end
      FsmParScan: begin
        if (rd_vld_q) begin
          if (!loc_vac_q[p_q] && loc_rd_q == par_q) begin
            found_d = 1'b1;
            fp_d = p_q;
            c_d = '0;
            stat_d = StFull;
          end else if (p_q != LLast) begin
            p_d = p_q + 1'b1;
          end
        end
      end
      FsmChildPlace: begin
        if (chd_vac_q[k_place]) begin
          chd_we = 1'b1;
          stat_d = StPlaced;
        end else if (c_q != CLast) begin
          c_d = c_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  logic idx_move;
  assign idx_move = (p_d != p_q) || (c_d != c_q) || (state_d != state_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FsmIdle;
      p_q       <= '0;
      c_q       <= '0;
      loc_vac_q <= '1;
      chd_vac_q <= '1;
      gw_q      <= 1'b0;
      outv_q    <= 1'b0;
      rd_vld_q  <= 1'b0;
      need_q    <= 1'b0;
      found_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      p_q      <= p_d;
      c_q      <= c_d;
      need_q   <= need_d;
      found_q  <= found_d;
      rd_vld_q <= !idx_move && !accept;
      if (cfg_valid_i) gw_q <= cfg_data_i;
      if (state_q == FsmChildScan && rd_vld_q) begin
        if (chd_hit) chd_vac_q[k_scan] <= 1'b1;
      end
      // Command 1 vacates a matching local slot before its children are scanned.
      if (state_q == FsmLocScan && rd_vld_q && loc_hit) loc_vac_q[p_q] <= 1'b1;
      if (loc_we) loc_vac_q[loc_wa] <= 1'b0;
      if (chd_we) chd_vac_q[chd_wa] <= 1'b0;
      if (state_q == FsmDone && state_d == FsmIdle) outv_q <= 1'b1;
      else if (outv_q && !stall_i) outv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    dest_q <= dest_d;
    fp_q   <= fp_d;
    stat_q <= stat_d;
    if (accept) begin
      cmd_q <= command_i;
      dev_q <= device_id_i;
      par_q <= parent_id_i;
    end
    if (state_q == FsmDone && state_d == FsmIdle) begin
      status_o        <= stat_q;
      remove_needed_o <= need_q;
      remove_dest_o   <= need_q ? dest_q : '0;
      remove_device_o <= need_q ? dev_q : '0;
    end
  end

  assign valid_o = outv_q;
endmodule
`default_nettype wire

// ===== rtl/core/madt_checker.sv =====
// Port-level checker for the mesh attached device table, bound to the top level.
`default_nettype none
module madt_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       valid_i,
  input wire logic       stall_o,
  input wire logic       valid_o,
  input wire logic       stall_i,
  input wire logic [1:0] status_o,
  input wire logic       remove_needed_o,
  input wire logic [31:0] remove_dest_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(status_o)) else $error("output dropped");
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> status_o != 2'd3) else $error("bad status");
  a_dest_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !remove_needed_o |-> remove_dest_o == 32'd0) else $error("dest");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !stall_o |=> stall_o) else $error("took two items");
endmodule

bind mesh_attached_device_table_unit madt_checker u_madt_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(valid_i), .stall_o(stall_o),
  .valid_o(valid_o), .stall_i(stall_i), .status_o(status_o),
  .remove_needed_o(remove_needed_o), .remove_dest_o(remove_dest_o)
);
`default_nettype wire
